[hw/rtl/kli_pkg.sv]
// shared types and constants of the keyframe interpolator
package kli_pkg;

  localparam int VAL_W    = 32;
  localparam int POSE_LEN = 5;
  localparam int MODE_W   = 2;
  localparam int STEPS_W  = 16;
  localparam int OUT_CNT_W = 4;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd60;

  localparam logic [MODE_W-1:0] MODE_SAVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  // element 0 is x, then y, z, knee, turn
  typedef logic [POSE_LEN-1:0][VAL_W-1:0] pose_t;

endpackage

[hw/rtl/kli_ifs.sv]
// valid/ready channel interfaces of the keyframe interpolator
interface kli_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic        [kli_pkg::MODE_W-1:0]    mode;
  logic signed [kli_pkg::VAL_W-1:0]     pos_x;
  logic signed [kli_pkg::VAL_W-1:0]     pos_y;
  logic signed [kli_pkg::VAL_W-1:0]     pos_z;
  logic signed [kli_pkg::VAL_W-1:0]     knee_angle;
  logic signed [kli_pkg::VAL_W-1:0]     turn_angle;

  modport source(output valid, mode, pos_x, pos_y, pos_z, knee_angle, turn_angle,
                 input ready);
  modport sink(input valid, mode, pos_x, pos_y, pos_z, knee_angle, turn_angle,
               output ready);
endinterface

interface kli_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kli_pkg::VAL_W-1:0]     cur_x;
  logic signed [kli_pkg::VAL_W-1:0]     cur_y;
  logic signed [kli_pkg::VAL_W-1:0]     cur_z;
  logic signed [kli_pkg::VAL_W-1:0]     cur_knee;
  logic signed [kli_pkg::VAL_W-1:0]     cur_turn;
  logic                                 is_playing;
  logic                                 play_ended;
  logic        [kli_pkg::OUT_CNT_W-1:0] stored_frames;
  logic                                 save_rejected;

  modport source(output valid, cur_x, cur_y, cur_z, cur_knee, cur_turn, is_playing,
                 play_ended, stored_frames, save_rejected, input ready);
  modport sink(input valid, cur_x, cur_y, cur_z, cur_knee, cur_turn, is_playing,
               play_ended, stored_frames, save_rejected, output ready);
endinterface

interface kli_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kli_pkg::STEPS_W-1:0]   steps_per_segment;

  modport source(output valid, steps_per_segment, input ready);
  modport sink(input valid, steps_per_segment, output ready);
endinterface

[hw/rtl/kli_div.sv]
// radix-2 restoring divider: signed 33-bit difference by unsigned step count
module kli_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kli_pkg::VAL_W:0]       diff,
  input  logic [kli_pkg::STEPS_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [kli_pkg::VAL_W-1:0]     quo
);

  localparam int DW    = kli_pkg::VAL_W + 1;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]                 q;
  logic [kli_pkg::STEPS_W-1:0]   rem;
  logic [kli_pkg::STEPS_W-1:0]   dvs;
  logic                          neg;
  logic [CNT_W-1:0]              cnt;
  logic [kli_pkg::STEPS_W:0]     trial;
  logic                          fits;

  assign trial = {rem, q[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
        neg  <= diff[DW-1];
        q    <= diff[DW-1] ? (~diff + DW'(1)) : diff;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // shift one dividend bit into the remainder, subtract when it fits
        rem <= fits ? kli_pkg::STEPS_W'(trial - {1'b0, dvs}) : trial[kli_pkg::STEPS_W-1:0];
        q   <= {q[DW-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // truncation toward zero: negate the magnitude quotient, keep low 32 bits
  assign quo = neg ? (~q[kli_pkg::VAL_W-1:0] + kli_pkg::VAL_W'(1)) : q[kli_pkg::VAL_W-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("divider done without a running division");

endmodule

[hw/rtl/keyframe_linear_interpolator.sv]
// top level: keyframe store, playback sequencer and pose accumulator
//
// channels: cmd takes one word per item (mode, and the pose for a save),
// result gives one word per item (pose after the item and status flags),
// cfg writes steps_per_segment at any handshake (ready is always high).
// save, stop, a plain tick, a tick that ends playback and an unused mode
// load the result register from S_PUSH, the state after the accept edge.
// a play start and a tick that moves to the next segment run a segment
// setup: two reads of the frame memory (one registered read port) and five
// increments through a single bit-serial divider of 33 steps each, one
// after the other; the result register is loaded from S_PUSH after the
// fifth increment.
// one item is in work at a time; cmd is ready in idle even while the
// previous result still waits in the output register, and a finished item
// waits in its last state until the output register is free, so each
// stalled cycle at the receiver lengthens the item.
// reset clears frame count, pose, increments, playback and the result valid
// flag, and sets steps_per_segment to 60; the frame memory is not
// cleared since only written rows are ever read.
module keyframe_linear_interpolator #(
  parameter int FRAME_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  kli_cmd_if.sink   cmd,
  kli_res_if.source result,
  kli_cfg_if.sink   cfg
);

  localparam int SEG_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
  localparam int VW    = kli_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RDA, S_RDB, S_LATB, S_DSTART, S_DWAIT, S_PUSH
  } state_t;

  state_t                         state;
  logic [CNT_W-1:0]               fc;
  logic [SEG_W-1:0]               seg;
  logic [kli_pkg::STEPS_W-1:0]    step_cnt;
  logic [kli_pkg::STEPS_W-1:0]    steps;
  logic                           playing;
  logic                           start_load;
  logic                           ended;
  logic                           rejected;
  logic [2:0]                     comp;
  kli_pkg::pose_t                 pose;
  kli_pkg::pose_t                 incr;
  kli_pkg::pose_t                 row_a;
  kli_pkg::pose_t                 row_b;

  kli_pkg::pose_t                 mem [FRAME_DEPTH];
  kli_pkg::pose_t                 mem_q;
  logic [SEG_W-1:0]               rd_addr;
  logic                           mem_we;
  kli_pkg::pose_t                 cmd_pose;

  logic                           cmd_fire;
  logic                           store_full;
  logic                           last_seg;
  logic                           push;

  logic                           div_start;
  logic                           div_busy;
  logic                           div_done;
  logic [VW:0]                    div_diff;
  logic [kli_pkg::STEPS_W-1:0]    div_divisor;
  logic [VW-1:0]                  div_quo;

  logic                           out_valid;
  kli_pkg::pose_t                 out_pose;
  logic                           out_playing;
  logic                           out_ended;
  logic [kli_pkg::OUT_CNT_W-1:0]  out_frames;
  logic                           out_rejected;

  assign cmd.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign store_full = (fc >= CNT_W'(FRAME_DEPTH));
  // next segment would run past the last stored frame
  assign last_seg   = ((CNT_W + 1)'(seg) + (CNT_W + 1)'(3)) > (CNT_W + 1)'(fc);
  assign push       = (state == S_PUSH) && (!out_valid || result.ready);

  assign cmd_pose[0] = cmd.pos_x;
  assign cmd_pose[1] = cmd.pos_y;
  assign cmd_pose[2] = cmd.pos_z;
  assign cmd_pose[3] = cmd.knee_angle;
  assign cmd_pose[4] = cmd.turn_angle;

  assign mem_we  = cmd_fire && (cmd.mode == kli_pkg::MODE_SAVE) && !store_full;
  assign rd_addr = (state == S_RDB) ? (seg + SEG_W'(1)) : seg;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fc[SEG_W-1:0]] <= cmd_pose;
    end
    mem_q <= mem[rd_addr];
  end

  assign div_start   = (state == S_DSTART);
  assign div_diff    = {row_b[comp][VW-1], row_b[comp]} - {row_a[comp][VW-1], row_a[comp]};
  assign div_divisor = (steps == '0) ? kli_pkg::STEPS_W'(1) : steps;

  kli_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .diff    (div_diff),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quo     (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fc         <= '0;
      seg        <= '0;
      step_cnt   <= '0;
      steps      <= kli_pkg::STEPS_RESET;
      playing    <= 1'b0;
      start_load <= 1'b0;
      ended      <= 1'b0;
      rejected   <= 1'b0;
      comp       <= '0;
      pose       <= '0;
      incr       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        steps <= cfg.steps_per_segment;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            ended    <= 1'b0;
            rejected <= 1'b0;
            state    <= S_PUSH;
            case (cmd.mode)
              kli_pkg::MODE_SAVE: begin
                if (store_full) begin
                  rejected <= 1'b1;
                end else begin
                  fc <= fc + CNT_W'(1);
                end
              end
              kli_pkg::MODE_PLAY: begin
                if (!playing && fc > CNT_W'(1)) begin
                  seg        <= '0;
                  step_cnt   <= '0;
                  playing    <= 1'b1;
                  start_load <= 1'b1;
                  state      <= S_RDA;
                end else begin
                  playing <= 1'b0;
                end
              end
              kli_pkg::MODE_TICK: begin
                if (playing) begin
                  if (step_cnt >= steps) begin
                    if (last_seg) begin
                      seg     <= '0;
                      playing <= 1'b0;
                      ended   <= 1'b1;
                    end else begin
                      seg        <= seg + SEG_W'(1);
                      step_cnt   <= '0;
                      start_load <= 1'b0;
                      state      <= S_RDA;
                    end
                  end else begin
                    for (int k = 0; k < kli_pkg::POSE_LEN; k++) begin
                      pose[k] <= pose[k] + incr[k];
                    end
                    step_cnt <= step_cnt + kli_pkg::STEPS_W'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          row_a <= mem_q;
          if (start_load) begin
            pose <= mem_q;
          end
          state <= S_LATB;
        end
        S_LATB: begin
          row_b <= mem_q;
          comp  <= '0;
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            incr[comp] <= div_quo;
            if (comp == 3'(kli_pkg::POSE_LEN - 1)) begin
              state <= S_PUSH;
            end else begin
              comp  <= comp + 3'(1);
              state <= S_DSTART;
            end
          end
        end
        S_PUSH: begin
          if (push) begin
            out_pose     <= pose;
            out_playing  <= playing;
            out_ended    <= ended;
            out_frames   <= kli_pkg::OUT_CNT_W'(fc);
            out_rejected <= rejected;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.cur_x         = out_pose[0];
  assign result.cur_y         = out_pose[1];
  assign result.cur_z         = out_pose[2];
  assign result.cur_knee      = out_pose[3];
  assign result.cur_turn      = out_pose[4];
  assign result.is_playing    = out_playing;
  assign result.play_ended    = out_ended;
  assign result.stored_frames = out_frames;
  assign result.save_rejected = out_rejected;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fc <= CNT_W'(FRAME_DEPTH))
    else $error("frame count beyond store depth");
  a_segment_in_store: assert property (@(posedge clk) disable iff (rst)
    playing |-> (((CNT_W + 1)'(seg) + (CNT_W + 1)'(2)) <= (CNT_W + 1)'(fc)))
    else $error("playback segment past stored frames");
  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.play_ended) |-> !result.is_playing)
    else $error("end of playback reported while playing");
  a_div_only_setup: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DWAIT))
    else $error("divider running outside segment setup");

endmodule

[tb/keyframe_linear_interpolator_tb.sv]
// self-checking testbench for keyframe_linear_interpolator: random handshakes, predicted poses
`timescale 1ns / 100ps

module keyframe_linear_interpolator_tb;

  localparam int FRAME_DEPTH = 8;
  localparam logic [kli_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int unsigned RUN_LIMIT = 500000;

  typedef struct {
    logic [kli_pkg::MODE_W-1:0] mode;
    kli_pkg::pose_t             pose;
  } cmd_word_t;

  typedef struct {
    kli_pkg::pose_t                pose;
    logic                          playing;
    logic                          ended;
    logic [kli_pkg::OUT_CNT_W-1:0] frames;
    logic                          rejected;
  } pose_report_t;

  logic clk = 1'b0;
  logic rst;

  kli_cmd_if cmd_bus();
  kli_res_if res_bus();
  kli_cfg_if cfg_bus();

  keyframe_linear_interpolator #(.FRAME_DEPTH(FRAME_DEPTH)) u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  always #6 clk = ~clk;

  // predicted block state
  kli_pkg::pose_t key_store [FRAME_DEPTH];
  int             key_count;
  kli_pkg::pose_t acc_pose;
  kli_pkg::pose_t step_incr;
  int             seg_idx;
  logic [15:0]    tick_count;
  logic           running;
  logic [15:0]    steps;

  cmd_word_t     pending_cmds [$];
  pose_report_t  expected_reports [$];
  cmd_word_t     cmd_word;
  int            cmd_hold;
  int            res_hold;
  bit            cmd_calm;
  bit            res_calm;
  int            items_queued;
  int            results_seen;
  int            mismatches;
  int            gen_frames;
  int unsigned   cycle_count;

  function automatic int idle_draw(bit calm);
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic kli_pkg::pose_t random_pose();
    kli_pkg::pose_t p;
    int k;
    for (k = 0; k < kli_pkg::POSE_LEN; k++) p[k] = $urandom;
    return p;
  endfunction

  // (next - current) / steps (zero steps as one), truncated toward zero, low 32 bits kept
  function automatic void load_increments();
    longint diff;
    longint divisor;
    longint quot;
    int k;
    divisor = (steps == 16'd0) ? 64'sd1 : longint'(steps);
    for (k = 0; k < kli_pkg::POSE_LEN; k++) begin
      if (seg_idx + 1 >= FRAME_DEPTH) begin
        step_incr[k] = '0;
      end else begin
        diff = longint'($signed(key_store[seg_idx + 1][k]))
             - longint'($signed(key_store[seg_idx][k]));
        quot = diff / divisor;
        step_incr[k] = quot[31:0];
      end
    end
  endfunction

  function automatic pose_report_t advance_pose(cmd_word_t c);
    pose_report_t r;
    int k;
    r.ended = 1'b0;
    r.rejected = 1'b0;
    case (c.mode)
      kli_pkg::MODE_SAVE: begin
        if (key_count < FRAME_DEPTH) begin
          key_store[key_count] = c.pose;
          key_count++;
        end else begin
          r.rejected = 1'b1;
        end
      end
      kli_pkg::MODE_PLAY: begin
        if (!running && key_count > 1) begin
          acc_pose = key_store[0];
          seg_idx = 0;
          load_increments();
          tick_count = '0;
          running = 1'b1;
        end else begin
          running = 1'b0;
        end
      end
      kli_pkg::MODE_TICK: begin
        if (running) begin
          if (tick_count >= steps) begin
            // segment boundary: pose holds on this tick
            seg_idx++;
            if (seg_idx + 2 > key_count) begin
              seg_idx = 0;
              running = 1'b0;
              r.ended = 1'b1;
            end else begin
              tick_count = '0;
              load_increments();
            end
          end else begin
            for (k = 0; k < kli_pkg::POSE_LEN; k++) acc_pose[k] = acc_pose[k] + step_incr[k];
            tick_count = tick_count + 16'd1;
          end
        end
      end
      default: ;
    endcase
    r.pose = acc_pose;
    r.playing = running;
    r.frames = key_count[kli_pkg::OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %h got %h", name, want, got);
      mismatches++;
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid      <= 1'b0;
      cmd_bus.mode       <= kli_pkg::MODE_TICK;
      cmd_bus.pos_x      <= '0;
      cmd_bus.pos_y      <= '0;
      cmd_bus.pos_z      <= '0;
      cmd_bus.knee_angle <= '0;
      cmd_bus.turn_angle <= '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) expected_reports.push_back(advance_pose(cmd_word));
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_hold > 0) begin
          cmd_hold--;
          cmd_bus.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_word = pending_cmds.pop_front();
          cmd_bus.mode       <= cmd_word.mode;
          cmd_bus.pos_x      <= cmd_word.pose[0];
          cmd_bus.pos_y      <= cmd_word.pose[1];
          cmd_bus.pos_z      <= cmd_word.pose[2];
          cmd_bus.knee_angle <= cmd_word.pose[3];
          cmd_bus.turn_angle <= cmd_word.pose[4];
          cmd_bus.valid      <= 1'b1;
          cmd_hold = idle_draw(cmd_calm);
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pose_report_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (expected_reports.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("cur_x", want.pose[0], res_bus.cur_x);
          compare_field("cur_y", want.pose[1], res_bus.cur_y);
          compare_field("cur_z", want.pose[2], res_bus.cur_z);
          compare_field("cur_knee", want.pose[3], res_bus.cur_knee);
          compare_field("cur_turn", want.pose[4], res_bus.cur_turn);
          compare_field("is_playing", want.playing, res_bus.is_playing);
          compare_field("play_ended", want.ended, res_bus.play_ended);
          compare_field("stored_frames", want.frames, res_bus.stored_frames);
          compare_field("save_rejected", want.rejected, res_bus.save_rejected);
        end
        res_hold = idle_draw(res_calm);
      end
      if (res_hold > 0) begin
        res_hold--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_item(logic [kli_pkg::MODE_W-1:0] m, kli_pkg::pose_t p);
    cmd_word_t w;
    w.mode = m;
    w.pose = p;
    pending_cmds.push_back(w);
    items_queued++;
  endtask

  task automatic queue_save(kli_pkg::pose_t p);
    if (gen_frames < FRAME_DEPTH) gen_frames++;
    queue_item(kli_pkg::MODE_SAVE, p);
  endtask

  task automatic settle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_steps(logic [15:0] v);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.steps_per_segment <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    steps = v;
    cfg_bus.valid <= 1'b0;
  endtask

  // start playback and tick to its end, with some noise and some early stops
  task automatic queue_playback();
    int ticks;
    int cut;
    int n;
    if ($urandom_range(0, 5) == 0) queue_item(kli_pkg::MODE_TICK, random_pose());
    if ($urandom_range(0, 1) == 0) queue_save(random_pose());
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    if (gen_frames < 2) return;
    ticks = (gen_frames - 1) * (int'(steps) + 1);
    cut = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, ticks - 1)) : ticks;
    for (n = 0; n < cut; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_item(MODE_UNUSED, random_pose());
        end else begin
          // a save while playing adds a segment if there is room
          if (gen_frames < FRAME_DEPTH) begin
            if (cut == ticks) cut += int'(steps) + 1;
            ticks += int'(steps) + 1;
          end
          queue_save(random_pose());
        end
      end
      queue_item(kli_pkg::MODE_TICK, random_pose());
    end
    if (cut < ticks) queue_item(kli_pkg::MODE_PLAY, random_pose());
  endtask

  initial begin
    kli_pkg::pose_t min_pose;
    kli_pkg::pose_t max_pose;
    int ph;
    int ticks;
    logic [15:0] v;

    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.steps_per_segment = kli_pkg::STEPS_RESET;
    key_count = 0;
    acc_pose = '0;
    step_incr = '0;
    seg_idx = 0;
    tick_count = '0;
    running = 1'b0;
    steps = kli_pkg::STEPS_RESET;
    cmd_hold = 0;
    res_hold = 0;
    cmd_calm = 1'b0;
    res_calm = 1'b0;
    items_queued = 0;
    results_seen = 0;
    mismatches = 0;
    gen_frames = 0;
    cycle_count = 0;
    min_pose = {kli_pkg::POSE_LEN{32'h8000_0000}};
    max_pose = {kli_pkg::POSE_LEN{32'h7fff_ffff}};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset steps: idle tick, unused mode, play with too few frames, then play, ticks, stop
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(MODE_UNUSED, random_pose());
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_save(min_pose);
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_save(max_pose);
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(MODE_UNUSED, random_pose());
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    settle();

    // one step: full-range difference wraps onto the next frame
    set_steps(16'd1);
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    settle();

    // zero steps divides as one, save during playback
    set_steps(16'd0);
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_save({32'hffff_ffff, 32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff});
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    settle();

    set_steps(16'hffff);
    queue_item(kli_pkg::MODE_PLAY, random_pose());
    queue_item(kli_pkg::MODE_TICK, random_pose());
    queue_item(kli_pkg::MODE_PLAY, random_pose());

    for (ph = 0; ph < 8; ph++) begin
      settle();
      cmd_calm = ($urandom_range(0, 3) == 0);
      res_calm = ($urandom_range(0, 3) == 0);
      case (ph)
        2:       v = 16'd0;
        5:       v = 16'd9;
        default: v = 16'($urandom_range(1, 4));
      endcase
      set_steps(v);
      // playback left running: new step count takes effect mid-segment
      if (running) begin
        repeat ($urandom_range(1, 3)) queue_item(kli_pkg::MODE_TICK, random_pose());
        settle();
        if (running) begin
          queue_item(kli_pkg::MODE_PLAY, random_pose());
          settle();
        end
      end
      ticks = items_queued;
      while (items_queued - ticks < 30) queue_playback();
      if ($urandom_range(0, 1) == 0 && gen_frames >= 2) begin
        ticks = (gen_frames - 1) * (int'(steps) + 1);
        queue_item(kli_pkg::MODE_PLAY, random_pose());
        repeat ($urandom_range(0, ticks - 1)) queue_item(kli_pkg::MODE_TICK, random_pose());
      end
    end
    settle();

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      if (expected_reports.size() != 0)
        $error("%0d expected result words never arrived", expected_reports.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
